>>> sv/psrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and constants of the per-source rate limiter
// Table size, field widths, register map and reset values of the registers.
// ----------------------------------------------------------------------------
package psrl_pkg;

  // Number of table entries (1 .. 256)
  localparam int ENTRIES = 16;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;
  localparam int MS_W   = 31;
  localparam int CNT_W  = 8;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  // Register map, index = byte address / 4
  typedef enum logic [1:0] {
    REG_WINDOW_MS    = 2'd0,
    REG_MAX_REQUESTS = 2'd1,
    REG_BLOCK_MS     = 2'd2,
    REG_IDLE_MS      = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [MS_W-1:0]  WINDOW_MS_RST    = MS_W'(60000);
  localparam logic [CNT_W-1:0] MAX_REQUESTS_RST = CNT_W'(5);
  localparam logic [MS_W-1:0]  BLOCK_MS_RST     = MS_W'(180000);
  localparam logic [MS_W-1:0]  IDLE_MS_RST      = MS_W'(600000);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // One table entry (payload only, valid bit kept apart)
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] window_start;
    logic [CNT_W-1:0]  request_count;
    logic              blocked;
    logic [TIME_W-1:0] block_end;
  } entry_t;

endpackage

>>> sv/psrl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_if: request and verdict channels of the per-source rate limiter
// Valid/ready channels; a beat moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface psrl_in_if import psrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] source_addr;
  logic [TIME_W-1:0] time_now;

  modport source (output valid, output source_addr, output time_now, input ready);
  modport sink   (input valid, input source_addr, input time_now, output ready);
endinterface

interface psrl_out_if import psrl_pkg::*; ();
  logic valid;
  logic ready;
  logic allowed;
  logic newly_blocked;
  logic table_full;

  modport source (output valid, output allowed, output newly_blocked,
                  output table_full, input ready);
  modport sink   (input valid, input allowed, input newly_blocked,
                  input table_full, output ready);
endinterface

>>> sv/per_source_rate_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_rate_limiter: fixed-window request limiter with temporary block
// Fully associative per-source table; one verdict beat per request beat.
// ----------------------------------------------------------------------------
// Pipeline: lookup stage, then result register. Throughput: one request per
//   cycle while the verdict channel is not stalled, set by the parallel
//   compare of all table entries in the lookup stage.
// Reset: registers return to their defaults and all entry valid bits clear
//   in the same cycle; no clearing pass, requests are taken right away.
// ----------------------------------------------------------------------------
module per_source_rate_limiter import psrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  psrl_in_if.sink           in_chan,
  psrl_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers
  logic [MS_W-1:0]  window_ms_r;
  logic [CNT_W-1:0] max_requests_r;
  logic [MS_W-1:0]  block_ms_r;
  logic [MS_W-1:0]  idle_ms_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;

  // Lookup stage
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_go;

  // Table
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  entry_t             entry_r   [ENTRIES];
  entry_t             entry_nxt [ENTRIES];

  // Lookup results
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] active_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] match_1h;
  logic [ENTRIES-1:0] free_1h;
  logic               hit;
  logic               slot_ok;
  logic               hit_active;
  entry_t             hit_e;
  entry_t             upd_e;
  entry_t             new_e;
  logic [TIME_W-1:0]  d_block;
  logic [TIME_W-1:0]  last_act;
  logic [TIME_W-1:0]  idle_d;
  logic [TIME_W-1:0]  eff_ws;
  logic [CNT_W-1:0]   eff_cnt;
  logic [CNT_W-1:0]   cnt_inc;

  // Verdict
  logic allowed_c;
  logic newly_c;
  logic full_c;

  // Result register
  logic out_valid_r;
  logic out_valid_nxt;
  logic allowed_r;
  logic newly_blocked_r;
  logic table_full_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r    <= WINDOW_MS_RST;
      max_requests_r <= MAX_REQUESTS_RST;
      block_ms_r     <= BLOCK_MS_RST;
      idle_ms_r      <= IDLE_MS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_WINDOW_MS:    window_ms_r    <= pwdata[MS_W-1:0];
        REG_MAX_REQUESTS: max_requests_r <= pwdata[CNT_W-1:0];
        REG_BLOCK_MS:     block_ms_r     <= pwdata[MS_W-1:0];
        REG_IDLE_MS:      idle_ms_r      <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (cfg_sel)
      REG_WINDOW_MS:    prdata = CFG_DW'(window_ms_r);
      REG_MAX_REQUESTS: prdata = CFG_DW'(max_requests_r);
      REG_BLOCK_MS:     prdata = CFG_DW'(block_ms_r);
      REG_IDLE_MS:      prdata = CFG_DW'(idle_ms_r);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: advance the lookup stage when the result register frees up
  // --------------------------------------------------------------------------
  assign s1_go         = s1_valid_r & (~out_valid_r | out_chan.ready);
  assign in_chan.ready = ~s1_valid_r | s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_addr_r <= in_chan.source_addr;
      s1_now_r  <= in_chan.time_now;
    end
  end

  // --------------------------------------------------------------------------
  // Parallel compare over all entries: address match, active block, free
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i]  = valid_r[i] && (entry_r[i].addr == s1_addr_r);
      d_block       = entry_r[i].block_end - s1_now_r;
      active_vec[i] = entry_r[i].blocked && (d_block != '0) && !d_block[TIME_W-1];
      last_act      = entry_r[i].blocked ? entry_r[i].block_end : entry_r[i].window_start;
      idle_d        = s1_now_r - last_act;
      free_vec[i]   = !valid_r[i] ||
                      (!active_vec[i] && (idle_d > TIME_W'(idle_ms_r)));
    end
  end

  // Keep the lowest set bit
  assign match_1h = match_vec & (~match_vec + ENTRIES'(1));
  assign free_1h  = free_vec & (~free_vec + ENTRIES'(1));
  assign hit      = |match_vec;
  assign slot_ok  = |free_vec;

  // Select the matching entry
  always_comb begin
    hit_e      = '0;
    hit_active = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_1h[i]) begin
        hit_e      = entry_r[i];
        hit_active = active_vec[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Update of a known source, and the entry for a new one
  // --------------------------------------------------------------------------
  always_comb begin
    upd_e     = hit_e;
    allowed_c = 1'b0;
    newly_c   = 1'b0;
    full_c    = 1'b0;
    // an expired block restarts the window from zero
    eff_ws    = hit_e.blocked ? s1_now_r : hit_e.window_start;
    eff_cnt   = hit_e.blocked ? '0 : hit_e.request_count;
    cnt_inc   = (eff_cnt != CNT_MAX) ? eff_cnt + CNT_W'(1) : CNT_MAX;

    new_e               = '0;
    new_e.addr          = s1_addr_r;
    new_e.window_start  = s1_now_r;
    new_e.request_count = CNT_W'(1);

    if (hit) begin
      if (!hit_active) begin
        upd_e.blocked = 1'b0;
        if ((s1_now_r - eff_ws) >= TIME_W'(window_ms_r)) begin
          // fresh window
          upd_e.window_start  = s1_now_r;
          upd_e.request_count = CNT_W'(1);
          allowed_c           = 1'b1;
        end else begin
          upd_e.window_start  = eff_ws;
          upd_e.request_count = cnt_inc;
          if (cnt_inc > max_requests_r) begin
            upd_e.blocked   = 1'b1;
            upd_e.block_end = s1_now_r + TIME_W'(block_ms_r);
            newly_c         = 1'b1;
          end else begin
            allowed_c = 1'b1;
          end
        end
      end
    end else if (slot_ok) begin
      allowed_c = 1'b1;
    end else begin
      full_c = 1'b1;
    end
  end

  // Route the update to the chosen entry
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < ENTRIES; i++) begin
      entry_nxt[i] = entry_r[i];
      if (s1_go) begin
        if (hit) begin
          if (match_1h[i]) begin
            entry_nxt[i] = upd_e;
          end
        end else if (free_1h[i]) begin
          entry_nxt[i] = new_e;
          valid_nxt[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      entry_r[i] <= entry_nxt[i];
    end
  end

  // --------------------------------------------------------------------------
  // Result register: load on advance, drop once the beat is taken
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      allowed_r       <= allowed_c;
      newly_blocked_r <= newly_c;
      table_full_r    <= full_c;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.allowed       = allowed_r;
  assign out_chan.newly_blocked = newly_blocked_r;
  assign out_chan.table_full    = table_full_r;

endmodule

>>> tb/psrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_checker: verdict predictor and scoreboard for the rate limiter
// Watches the request, verdict and register channels, keeps its own copy of
// the source table and registers, and compares every verdict beat in order.
// ----------------------------------------------------------------------------
module psrl_checker import psrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  psrl_in_if                req_mon,
  psrl_out_if               verdict_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                n_requests,
  output int                n_allowed,
  output int                n_blocks,
  output int                n_full
);

  typedef struct packed {
    logic allowed;
    logic newly_blocked;
    logic table_full;
  } verdict_t;

  // Shadow copy of the registers
  logic [MS_W-1:0]  win_len;
  logic [CNT_W-1:0] req_limit;
  logic [MS_W-1:0]  block_len;
  logic [MS_W-1:0]  idle_len;

  // Shadow copy of the source table
  logic              tbl_valid     [ENTRIES];
  logic [ADDR_W-1:0] tbl_addr      [ENTRIES];
  logic [TIME_W-1:0] tbl_win_start [ENTRIES];
  logic [CNT_W-1:0]  tbl_count     [ENTRIES];
  logic              tbl_blocked   [ENTRIES];
  logic [TIME_W-1:0] tbl_block_end [ENTRIES];

  verdict_t verdicts_due[$];

  int mismatches;
  int seen_requests;
  int seen_allowed;
  int seen_blocks;
  int seen_full;

  // A block holds while its end lies strictly ahead within half the time range
  function automatic bit block_live(input int i, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] left;
    left = tbl_block_end[i] - now;
    return tbl_blocked[i] && (left != '0) && !left[TIME_W-1];
  endfunction

  // An entry may be taken when empty, or idle too long without a live block
  function automatic bit slot_free(input int i, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] last;
    logic [TIME_W-1:0] idle_for;
    if (!tbl_valid[i]) return 1'b1;
    if (block_live(i, now)) return 1'b0;
    last     = tbl_blocked[i] ? tbl_block_end[i] : tbl_win_start[i];
    idle_for = now - last;
    return idle_for > TIME_W'(idle_len);
  endfunction

  // Judge one request and update the table as the block should
  function automatic verdict_t judge_request(input logic [ADDR_W-1:0] addr,
                                             input logic [TIME_W-1:0] now);
    int                hit;
    int                slot;
    logic [TIME_W-1:0] age;
    verdict_t          v;
    hit  = -1;
    slot = -1;
    v    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_addr[i] == addr) hit = i;
    end
    if (hit >= 0) begin
      if (!block_live(hit, now)) begin
        // Expired block: restart the source from scratch
        if (tbl_blocked[hit]) begin
          tbl_blocked[hit]   = 1'b0;
          tbl_count[hit]     = '0;
          tbl_win_start[hit] = now;
        end
        age = now - tbl_win_start[hit];
        if (age >= TIME_W'(win_len)) begin
          tbl_win_start[hit] = now;
          tbl_count[hit]     = CNT_W'(1);
          v.allowed          = 1'b1;
        end else begin
          if (tbl_count[hit] != CNT_MAX) tbl_count[hit] = tbl_count[hit] + CNT_W'(1);
          if (tbl_count[hit] > req_limit) begin
            tbl_blocked[hit]   = 1'b1;
            tbl_block_end[hit] = now + TIME_W'(block_len);
            v.newly_blocked    = 1'b1;
          end else begin
            v.allowed = 1'b1;
          end
        end
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && slot_free(i, now)) slot = i;
      end
      if (slot >= 0) begin
        tbl_valid[slot]     = 1'b1;
        tbl_addr[slot]      = addr;
        tbl_win_start[slot] = now;
        tbl_count[slot]     = CNT_W'(1);
        tbl_blocked[slot]   = 1'b0;
        tbl_block_end[slot] = '0;
        v.allowed           = 1'b1;
      end else begin
        v.table_full = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t got_v;
    verdict_t want_v;
    if (!rst_n) begin
      win_len   = WINDOW_MS_RST;
      req_limit = MAX_REQUESTS_RST;
      block_len = BLOCK_MS_RST;
      idle_len  = IDLE_MS_RST;
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      verdicts_due.delete();
    end else begin
      // Compare the verdict beat against the oldest prediction
      if (verdict_mon.valid && verdict_mon.ready) begin
        got_v = '{verdict_mon.allowed, verdict_mon.newly_blocked, verdict_mon.table_full};
        if (verdicts_due.size() == 0) begin
          $error("verdict beat with no request outstanding");
          mismatches++;
        end else begin
          want_v = verdicts_due.pop_front();
          check_field("allowed", want_v.allowed, got_v.allowed);
          check_field("newly_blocked", want_v.newly_blocked, got_v.newly_blocked);
          check_field("table_full", want_v.table_full, got_v.table_full);
          if (want_v.allowed) seen_allowed++;
          if (want_v.newly_blocked) seen_blocks++;
          if (want_v.table_full) seen_full++;
        end
      end
      // Predict the verdict of each request beat and queue it at the tail
      if (req_mon.valid && req_mon.ready) begin
        verdicts_due.insert(verdicts_due.size(),
                            judge_request(req_mon.source_addr, req_mon.time_now));
        seen_requests++;
      end
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[CFG_AW-1:2]))
          REG_WINDOW_MS:    win_len   = pwdata[MS_W-1:0];
          REG_MAX_REQUESTS: req_limit = pwdata[CNT_W-1:0];
          REG_BLOCK_MS:     block_len = pwdata[MS_W-1:0];
          REG_IDLE_MS:      idle_len  = pwdata[MS_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= verdicts_due.size();
    n_requests <= seen_requests;
    n_allowed  <= seen_allowed;
    n_blocks   <= seen_blocks;
    n_full     <= seen_full;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the per-source rate limiter
// Drives requests from small address pools with advancing timestamps under
// several register settings, stalls both channels at random, and reports.
// ----------------------------------------------------------------------------
module testbench;
  import psrl_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int n_requests;
  int n_allowed;
  int n_blocks;
  int n_full;

  // Stimulus controls for the sender and the receiver
  bit                src_gaps;
  bit                snk_gaps;
  bit                long_hold;
  logic [TIME_W-1:0] now_ms;

  psrl_in_if  req_chan ();
  psrl_out_if verdict_chan ();

  per_source_rate_limiter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (verdict_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  psrl_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_chan),
    .verdict_mon (verdict_chan),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_requests  (n_requests),
    .n_allowed   (n_allowed),
    .n_blocks    (n_blocks),
    .n_full      (n_full)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Write one register: setup cycle, then access cycle
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one request beat and hold it until taken
  task automatic send_req(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] t);
    int gap;
    gap = src_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid       <= 1'b1;
    req_chan.source_addr <= addr;
    req_chan.time_now    <= t;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every verdict is back
  task automatic settle();
    req_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reprogram the registers, then run bursts and singles, plus noise and time jumps when rough
  task automatic run_phase(input logic [MS_W-1:0] win, input logic [CNT_W-1:0] max_req,
                           input logic [MS_W-1:0] blk, input logic [MS_W-1:0] idle,
                           input int unsigned step, input int pool, input int items,
                           input logic [TIME_W-1:0] start, input bit hold,
                           input bit rough);
    logic [ADDR_W-1:0] pool_addr [32];
    logic [ADDR_W-1:0] who;
    int                sent;
    int                next_redraw;
    int                kind;
    int                burst;
    bit                hold_done;
    settle();
    cfg_write(REG_WINDOW_MS, CFG_DW'(win));
    cfg_write(REG_MAX_REQUESTS, CFG_DW'(max_req));
    cfg_write(REG_BLOCK_MS, CFG_DW'(blk));
    cfg_write(REG_IDLE_MS, CFG_DW'(idle));
    for (int i = 0; i < pool; i++) pool_addr[i] = $urandom;
    now_ms      = start;
    sent        = 0;
    next_redraw = 0;
    hold_done   = 1'b0;
    while (sent < items) begin
      if (sent >= next_redraw) begin
        src_gaps    = ($urandom_range(0, 3) != 0);
        snk_gaps    = ($urandom_range(0, 3) != 0);
        next_redraw = sent + 40;
      end
      if (hold && !hold_done && sent >= items / 2) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      kind = rough ? $urandom_range(0, 15) : $urandom_range(0, 12);
      if (kind <= 10) begin
        // Burst from one known source, closely spaced in time
        who   = pool_addr[$urandom_range(0, pool - 1)];
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          now_ms += $urandom_range(0, step / 4);
          send_req(who, now_ms);
          sent++;
        end
      end else if (kind <= 12) begin
        now_ms += $urandom_range(0, step);
        send_req(pool_addr[$urandom_range(0, pool - 1)], now_ms);
        sent++;
      end else if (kind <= 14) begin
        send_req($urandom, now_ms);
        sent++;
      end else begin
        case ($urandom_range(0, 2))
          0:       now_ms += $urandom_range(0, step * 20);
          1:       now_ms -= $urandom_range(0, step);
          default: now_ms = $urandom;
        endcase
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int w;
    verdict_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        verdict_chan.ready <= 1'b0;
        repeat (500) @(posedge clk);
        long_hold = 1'b0;
      end
      w = snk_gaps ? $urandom_range(0, 6) : 0;
      if (w > 0) begin
        verdict_chan.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      verdict_chan.ready <= 1'b1;
      @(posedge clk);
      while (!verdict_chan.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_chan.valid       <= 1'b0;
    req_chan.source_addr <= '0;
    req_chan.time_now    <= '0;
    src_gaps  = 1'b1;
    snk_gaps  = 1'b1;
    long_hold = 1'b0;
    now_ms    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks under the reset defaults
    send_req(32'h0000_0000, 32'h0000_0000);
    send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // five more in the window: the last one exceeds the limit and blocks
    for (int k = 1; k <= 5; k++) send_req(32'h0000_0000, TIME_W'(k));
    send_req(32'h0000_0000, 32'd6);
    // block ends exactly now: restart and allow
    send_req(32'h0000_0000, 32'd180005);
    // window elapsed across the time wrap
    send_req(32'hFFFF_FFFF, 32'd59999);
    // fill the table, then one new source finds no room
    for (int k = 0; k < 14; k++) send_req(32'h5A5A_5A5A + ADDR_W'(k), 32'd200000 + k);
    send_req(32'hC0A8_0001, 32'd200020);
    // long idle frees the stale entries; the lowest-indexed one is reused
    send_req(32'hC0A8_0001, 32'd900000);

    run_phase(MS_W'(60000), CNT_W'(5), MS_W'(180000), MS_W'(600000),
              30000, 12, 150, 32'd1000000, 1'b0, 1'b1);
    run_phase(MS_W'(100), CNT_W'(3), MS_W'(250), MS_W'(400),
              40, 20, 200, $urandom, 1'b1, 1'b1);
    run_phase(MS_W'(1), CNT_W'(0), MS_W'(0), MS_W'(0),
              3, 18, 120, $urandom, 1'b0, 1'b1);
    // half the time range on, so every older entry has gone idle
    run_phase('1, CNT_W'(254), '1, '1,
              1000, 1, 300, now_ms + 32'h8000_1000, 1'b0, 1'b0);
    run_phase(MS_W'(50), CNT_W'(1), MS_W'(30), MS_W'(20),
              25, 24, 180, $urandom, 1'b0, 1'b1);
    run_phase(MS_W'(2000), CNT_W'(8), MS_W'(5000), MS_W'(10000),
              400, 16, 200, 32'hFFFF_0000, 1'b1, 1'b1);

    settle();
    $display("summary: %0d requests judged under the reset defaults and six register settings",
             n_requests);
    $display("summary: %0d allowed, %0d blocks started, %0d refused on a full table",
             n_allowed, n_blocks, n_full);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin : watchdog
    #400000;
    $display("run timed out");
    $display("testbench: FAIL");
    $finish;
  end

endmodule
